[src/chtd_pkg.sv]
// Shared constants, types and helpers for the clustered hash table core.
package chtd_pkg;

   // Table geometry and data word layout
   localparam int MAX_CLUSTERS     = 4096;
   localparam int WAYS_PER_CLUSTER = 4;
   localparam int FLAG_POS         = 16;
   localparam int DEPTH_POS        = 18;
   localparam int SCORE_POS        = 48;

   localparam int SLOT_COUNT = MAX_CLUSTERS * WAYS_PER_CLUSTER;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CLUSTER_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int WAY_W      = (WAYS_PER_CLUSTER > 1) ? $clog2(WAYS_PER_CLUSTER) : 1;
   localparam int WAY_CNT_W  = $clog2(WAYS_PER_CLUSTER + 1);

   // Cluster count register and divisor
   localparam int CFG_W         = 13;
   localparam int CFG_RESET     = 4096;
   localparam int CNT_W         = $clog2(MAX_CLUSTERS + 1);
   localparam int DIV_W         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int KEY_W         = 64;
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = KEY_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DIV_STEPS);

   // Opcodes
   localparam logic [1:0] OP_PROBE  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // One decoded request handed from front to back
   typedef struct packed {
      logic [1:0]           op;
      logic [KEY_W-1:0]     key;
      logic [63:0]          data;
      logic [CLUSTER_W-1:0] cluster;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Pack the insert fields into one data word; overlapping fields OR together
   function automatic logic [63:0] pack_data(input logic [15:0] move,
                                             input logic [1:0]  flag,
                                             input logic [7:0]  depth,
                                             input logic [15:0] score);
      return 64'(move) | (64'(flag) << FLAG_POS) | (64'(depth) << DEPTH_POS)
           | (64'(score) << SCORE_POS);
   endfunction

   function automatic logic [7:0] depth_of(input logic [63:0] d);
      return 8'(d >> DEPTH_POS);
   endfunction

endpackage

[src/clustered_hash_table_depth_replace_core.sv]
// Top level of the clustered hash table with depth-preferred replacement.
//
// Requests: start with req_* fields is taken when busy is low. Opcode 0
// probes, 1 inserts, 2 clears the table, 3 is dropped.
// Responses: a probe gives one response, rsp_valid high for one cycle with
// rsp_* fields. The receiver cannot stall; results are always taken.
// csr_we/csr_wdata write the cluster count; write only while idle.
// Flow: the front reduces the key modulo the cluster count, 8 key bits a
// cycle, then hands the job to the queue. The back scans the cluster one
// way a cycle through the table's single read port, then raises the
// response strobe for a probe. The front takes no new request until its
// last one is pushed, but works while the back handles older ones; for
// probes and inserts the front's division, not the back's scan, sets the
// sustained rate.
// A clear sweeps all SLOT_COUNT (16384) entries, one entry a cycle.
// Reset: the cluster count returns to 4096 and the same clearing pass
// runs; busy stays high until it finishes.
module clustered_hash_table_depth_replace_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [63:0]                req_lookup_key,
   input  logic [15:0]                req_best_move,
   input  logic [1:0]                 req_bound_flag,
   input  logic [7:0]                 req_search_depth,
   input  logic signed [15:0]         req_eval_score,
   output logic                       rsp_valid,
   output logic                       rsp_key_matched,
   output logic [15:0]                rsp_entry_move,
   output logic [1:0]                 rsp_entry_flag,
   output logic [7:0]                 rsp_entry_depth,
   output logic signed [15:0]         rsp_entry_score,
   input  logic                       csr_we,
   input  logic [12:0]                csr_wdata
);

   logic [chtd_pkg::CFG_W-1:0] clusters_ff;
   logic                       front_busy, clearing, q_push, q_pop;
   chtd_pkg::job_type          push_job, head_job;
   chtd_pkg::q_stat_type       q_stat;

   assign busy = front_busy || clearing;

   // Cluster count register
   always_ff @(posedge clock) begin
      if (reset)       clusters_ff <= chtd_pkg::CFG_W'(chtd_pkg::CFG_RESET);
      else if (csr_we) clusters_ff <= csr_wdata;
   end

   chtd_front u_front (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_lookup_key, .req_best_move, .req_bound_flag,
      .req_search_depth, .req_eval_score,
      .clusters   (clusters_ff),
      .q_stat     (q_stat),
      .front_busy (front_busy),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   chtd_queue u_queue (
      .clock, .reset,
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   chtd_back u_back (
      .clock, .reset,
      .head_job (head_job),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_valid, .rsp_key_matched, .rsp_entry_move, .rsp_entry_flag,
      .rsp_entry_depth, .rsp_entry_score
   );

endmodule

[src/chtd_front.sv]
// Front end: accepts requests, reduces the key modulo the cluster count.
module chtd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [63:0]                   req_lookup_key,
   input  logic [15:0]                   req_best_move,
   input  logic [1:0]                    req_bound_flag,
   input  logic [7:0]                    req_search_depth,
   input  logic signed [15:0]            req_eval_score,
   input  logic [chtd_pkg::CFG_W-1:0]    clusters,
   input  chtd_pkg::q_stat_type          q_stat,
   output logic                          front_busy,
   output logic                          q_push,
   output chtd_pkg::job_type             q_job
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [chtd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [chtd_pkg::KEY_W-1:0]      shift_ff, shift_in;
   logic [chtd_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [chtd_pkg::DIV_W-1:0]      div_ff, div_in;
   chtd_pkg::job_type               job_ff, job_in;
   logic                            accept;
   logic [chtd_pkg::DIV_W-1:0]      cfg_ext;

   assign accept     = start && !busy;
   assign front_busy = (state_ff != F_IDLE);
   assign q_push     = (state_ff == F_PUSH) && !q_stat.full;
   assign q_job      = job_ff;
   assign cfg_ext    = chtd_pkg::DIV_W'(clusters);

   // Divisor clamp, restoring remainder steps, next state
   always_comb begin
      logic [chtd_pkg::DIV_W-1:0] r;
      logic [chtd_pkg::DIV_W:0]   t;
      logic [chtd_pkg::KEY_W-1:0] k;
      state_in = state_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      job_in   = job_ff;
      r = rem_ff;
      k = shift_ff;
      for (int i = 0; i < chtd_pkg::BITS_PER_STEP; i++) begin
         t = {r, k[chtd_pkg::KEY_W-1]};
         k = k << 1;
         if (t >= {1'b0, div_ff}) t = t - {1'b0, div_ff};
         r = t[chtd_pkg::DIV_W-1:0];
      end
      unique case (state_ff)
         F_IDLE: begin
            if (accept && req_opcode != chtd_pkg::OP_NONE) begin
               job_in.op   = req_opcode;
               job_in.key  = req_lookup_key;
               job_in.data = chtd_pkg::pack_data(req_best_move, req_bound_flag,
                                                 req_search_depth, req_eval_score);
               job_in.cluster = '0;
               shift_in = req_lookup_key;
               rem_in   = '0;
               step_in  = '0;
               if (cfg_ext == '0) div_in = chtd_pkg::DIV_W'(1);
               else if (cfg_ext > chtd_pkg::DIV_W'(chtd_pkg::MAX_CLUSTERS))
                  div_in = chtd_pkg::DIV_W'(chtd_pkg::MAX_CLUSTERS);
               else div_in = cfg_ext;
               state_in = (req_opcode == chtd_pkg::OP_CLEAR) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            shift_in = k;
            rem_in   = r;
            step_in  = step_ff + 1'b1;
            if (step_ff == chtd_pkg::STEP_W'(chtd_pkg::DIV_STEPS - 1)) begin
               job_in.cluster = chtd_pkg::CLUSTER_W'(r);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_stat.full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else       state_ff <= state_in;
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      job_ff   <= job_in;
   end

endmodule

[src/chtd_queue.sv]
// Two-entry request queue between front and back.
module chtd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  chtd_pkg::job_type    push_job,
   input  logic                 pop,
   output chtd_pkg::job_type    head_job,
   output chtd_pkg::q_stat_type stat
);

   chtd_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign head_job   = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[src/chtd_back.sv]
// Back end: cluster scan, insert write, clearing sweep, probe response.
module chtd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  chtd_pkg::job_type    head_job,
   input  chtd_pkg::q_stat_type q_stat,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output logic                 rsp_key_matched,
   output logic [15:0]          rsp_entry_move,
   output logic [1:0]           rsp_entry_flag,
   output logic [7:0]           rsp_entry_depth,
   output logic signed [15:0]   rsp_entry_score
);

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_CLEAR  = 3'd1;
   localparam logic [2:0] B_SCAN   = 3'd2;
   localparam logic [2:0] B_EVAL   = 3'd3;
   localparam logic [2:0] B_FINISH = 3'd4;

   logic [63:0] check_mem [chtd_pkg::SLOT_COUNT];
   logic [63:0] data_mem  [chtd_pkg::SLOT_COUNT];

   logic [2:0]                       state_ff, state_in;
   chtd_pkg::job_type                job_ff, job_in;
   logic [chtd_pkg::SLOT_W-1:0]      sweep_ff, sweep_in;
   logic [chtd_pkg::WAY_CNT_W-1:0]   way_ff, way_in;
   logic                             eval_vld_ff, eval_vld_in;
   logic [chtd_pkg::WAY_W-1:0]       eval_way_ff, eval_way_in;
   logic                             match_ff, match_in;
   logic [chtd_pkg::WAY_W-1:0]       sel_way_ff, sel_way_in;
   logic [63:0]                      sel_data_ff, sel_data_in;
   logic [63:0]                      rd_check_ff, rd_data_ff;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic                             rsp_match_ff;
   logic [63:0]                      rsp_data_ff;
   logic [chtd_pkg::SLOT_W-1:0]      base;
   logic [chtd_pkg::SLOT_W-1:0]      rd_addr;
   logic [chtd_pkg::SLOT_W-1:0]      wr_addr;
   logic                             wr_en;
   logic [63:0]                      wr_data, wr_check;

   assign base = chtd_pkg::SLOT_W'(job_ff.cluster) *
                 chtd_pkg::SLOT_W'(chtd_pkg::WAYS_PER_CLUSTER);
   assign rd_addr  = base + chtd_pkg::SLOT_W'(way_ff[chtd_pkg::WAY_W-1:0]);
   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_stat.empty;

   // Write port: sweep zeroes, insert stores data and check word
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = sweep_ff;
      wr_data  = '0;
      wr_check = '0;
      if (state_ff == B_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == B_FINISH && job_ff.op == chtd_pkg::OP_INSERT) begin
         wr_en    = 1'b1;
         wr_addr  = base + chtd_pkg::SLOT_W'(sel_way_ff);
         wr_data  = job_ff.data;
         wr_check = job_ff.key ^ job_ff.data;
      end
   end

   // Sequencer and way selection
   always_comb begin
      logic [63:0] tag;
      state_in    = state_ff;
      job_in      = job_ff;
      sweep_in    = sweep_ff;
      way_in      = way_ff;
      eval_vld_in = 1'b0;
      eval_way_in = eval_way_ff;
      match_in    = match_ff;
      sel_way_in  = sel_way_ff;
      sel_data_in = sel_data_ff;
      rsp_vld_in  = 1'b0;
      tag = rd_check_ff ^ rd_data_ff;
      if (eval_vld_ff && !match_ff) begin
         if (tag == job_ff.key) begin
            match_in    = 1'b1;
            sel_way_in  = eval_way_ff;
            sel_data_in = rd_data_ff;
         end else if (eval_way_ff == '0 ||
                      chtd_pkg::depth_of(rd_data_ff) < chtd_pkg::depth_of(sel_data_ff)) begin
            sel_way_in  = eval_way_ff;
            sel_data_in = rd_data_ff;
         end
      end
      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               job_in   = head_job;
               sweep_in = '0;
               way_in   = '0;
               match_in = 1'b0;
               state_in = (head_job.op == chtd_pkg::OP_CLEAR) ? B_CLEAR : B_SCAN;
            end
         end
         B_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == chtd_pkg::SLOT_W'(chtd_pkg::SLOT_COUNT - 1)) state_in = B_IDLE;
         end
         B_SCAN: begin
            eval_vld_in = 1'b1;
            eval_way_in = way_ff[chtd_pkg::WAY_W-1:0];
            way_in      = way_ff + 1'b1;
            if (way_ff == chtd_pkg::WAY_CNT_W'(chtd_pkg::WAYS_PER_CLUSTER - 1))
               state_in = B_EVAL;
         end
         B_EVAL: state_in = B_FINISH;
         B_FINISH: begin
            rsp_vld_in = (job_ff.op == chtd_pkg::OP_PROBE);
            state_in   = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Table memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         check_mem[wr_addr] <= wr_check;
         data_mem[wr_addr]  <= wr_data;
      end
      rd_check_ff <= check_mem[rd_addr];
      rd_data_ff  <= data_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         sweep_ff    <= '0;
         eval_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         eval_vld_ff <= eval_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      job_ff      <= job_in;
      way_ff      <= way_in;
      eval_way_ff <= eval_way_in;
      match_ff    <= match_in;
      sel_way_ff  <= sel_way_in;
      sel_data_ff <= sel_data_in;
      if (rsp_vld_in) begin
         rsp_match_ff <= match_ff;
         rsp_data_ff  <= sel_data_ff;
      end
   end

   // Response fields
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_key_matched = rsp_match_ff;
   assign rsp_entry_move  = rsp_data_ff[15:0];
   assign rsp_entry_flag  = 2'(rsp_data_ff >> chtd_pkg::FLAG_POS);
   assign rsp_entry_depth = chtd_pkg::depth_of(rsp_data_ff);
   assign rsp_entry_score = 16'(rsp_data_ff >> chtd_pkg::SCORE_POS);

endmodule

[src/chtd_checker.sv]
// Port-level checks for the hash table core, bound to the top level.
module chtd_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_opcode,
   input logic       rsp_valid
);

   // Reset always starts the clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // An accepted real request occupies the front
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != chtd_pkg::OP_NONE) |=> busy)
      else $error("busy low after accept");

   // Responses are spaced by the way scan
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   // No response right after reset
   a_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response right after reset");

endmodule

bind clustered_hash_table_depth_replace_core chtd_checker u_chtd_checker (
   .clock, .reset, .start, .busy, .req_opcode, .rsp_valid
);

[verif/tb_top.sv]
// Testbench for the clustered hash table core: queued requests, predicted probe replies.
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_CYCLES = 40;      // latency margin before a register write or the end
   localparam int STALL_LIMIT  = 60000;   // cycles with nothing taken (clear sweep covers 16384 entries)

   typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} kind_type;

   typedef struct {
      kind_type    kind;
      int          gap;
      logic [1:0]  op;
      logic [63:0] key;
      logic [15:0] move;
      logic [1:0]  flag;
      logic [7:0]  depth;
      logic [15:0] score;
      logic [12:0] cfg;
   } pending_type;

   typedef struct {
      logic        matched;
      logic [15:0] move;
      logic [1:0]  flag;
      logic [7:0]  depth;
      logic [15:0] score;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_opcode = chtd_pkg::OP_NONE;
   logic [63:0] req_lookup_key = '0;
   logic [15:0] req_best_move = '0;
   logic [1:0]  req_bound_flag = '0;
   logic [7:0]  req_search_depth = '0;
   logic signed [15:0] req_eval_score = '0;
   logic rsp_valid, rsp_key_matched;
   logic [15:0] rsp_entry_move;
   logic [1:0]  rsp_entry_flag;
   logic [7:0]  rsp_entry_depth;
   logic signed [15:0] rsp_entry_score;
   logic csr_we = 1'b0;
   logic [12:0] csr_wdata = '0;

   pending_type pending[$];
   reply_type   replies_due[$];
   logic [63:0] key_pool[$];

   // shadow of the table
   logic [63:0] shadow_check[chtd_pkg::SLOT_COUNT];
   logic [63:0] shadow_data[chtd_pkg::SLOT_COUNT];
   logic [12:0] shadow_clusters = 13'd4096;

   int  errors = 0;
   bit  took = 0;
   int  idle_cnt = 0;
   int  quiet = 0;
   int  stall = 0;
   bit  no_gaps = 0;

   always #2 clock = ~clock;

   clustered_hash_table_depth_replace_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_lookup_key(req_lookup_key),
      .req_best_move(req_best_move), .req_bound_flag(req_bound_flag),
      .req_search_depth(req_search_depth), .req_eval_score(req_eval_score),
      .rsp_valid(rsp_valid), .rsp_key_matched(rsp_key_matched),
      .rsp_entry_move(rsp_entry_move), .rsp_entry_flag(rsp_entry_flag),
      .rsp_entry_depth(rsp_entry_depth), .rsp_entry_score(rsp_entry_score),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // apply one request to the shadow table, queue a reply for a probe
   task automatic table_step(input logic [1:0] op, input logic [63:0] key,
                             input logic [63:0] word);
      logic [63:0] n;
      int base, slot, i;
      bit hit;
      reply_type r;
      if (op == chtd_pkg::OP_CLEAR) begin
         foreach (shadow_check[j]) begin
            shadow_check[j] = '0;
            shadow_data[j]  = '0;
         end
      end else if (op != chtd_pkg::OP_NONE) begin
         n = shadow_clusters;
         if (n < 1) n = 1;
         if (n > chtd_pkg::MAX_CLUSTERS) n = chtd_pkg::MAX_CLUSTERS;
         base = int'(key % n) * chtd_pkg::WAYS_PER_CLUSTER;
         hit = 0;
         slot = base;
         for (i = 0; i < chtd_pkg::WAYS_PER_CLUSTER; i++)
            if (!hit && (shadow_check[base+i] ^ shadow_data[base+i]) == key) begin
               hit = 1;
               slot = base + i;
            end
         if (!hit)
            for (i = 1; i < chtd_pkg::WAYS_PER_CLUSTER; i++)
               if (shadow_data[base+i][chtd_pkg::DEPTH_POS +: 8] <
                   shadow_data[slot][chtd_pkg::DEPTH_POS +: 8])
                  slot = base + i;
         if (op == chtd_pkg::OP_INSERT) begin
            shadow_data[slot]  = word;
            shadow_check[slot] = key ^ word;
         end else begin
            r.matched = hit;
            r.move    = shadow_data[slot][15:0];
            r.flag    = shadow_data[slot][chtd_pkg::FLAG_POS +: 2];
            r.depth   = shadow_data[slot][chtd_pkg::DEPTH_POS +: 8];
            r.score   = shadow_data[slot][chtd_pkg::SCORE_POS +: 16];
            replies_due.push_back(r);
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic add_req(input logic [1:0] op, input logic [63:0] key,
                          input logic [15:0] move, input logic [1:0] flag,
                          input logic [7:0] depth, input logic [15:0] score);
      pending_type p;
      p.kind = K_REQ; p.gap = pick_gap(); p.op = op; p.key = key;
      p.move = move; p.flag = flag; p.depth = depth; p.score = score; p.cfg = '0;
      pending.push_back(p);
   endtask

   task automatic add_ctrl(input kind_type kind, input logic [12:0] value);
      pending_type p;
      p = '{kind: kind, gap: 0, op: chtd_pkg::OP_NONE, key: '0, move: '0, flag: '0,
            depth: '0, score: '0, cfg: value};
      pending.push_back(p);
   endtask

   task automatic add_random(input int count, input bit clears);
      logic [63:0] key;
      logic [1:0]  op;
      int r;
      repeat (count) begin
         r = $urandom_range(999);
         if (r < 470) op = chtd_pkg::OP_PROBE;
         else if (r < 960) op = chtd_pkg::OP_INSERT;
         else if (r < 990 || !clears) op = chtd_pkg::OP_NONE;
         else op = chtd_pkg::OP_CLEAR;
         if ($urandom_range(9) < 8) key = key_pool[$urandom_range(key_pool.size() - 1)];
         else key = {$urandom, $urandom};
         add_req(op, key, 16'($urandom), 2'($urandom),
                 ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom),
                 16'($urandom));
      end
   endtask

   // stimulus
   initial begin
      logic [12:0] settings[$];
      for (int i = 0; i < 24; i++) key_pool.push_back({$urandom, $urandom});
      key_pool.push_back(64'd0);
      key_pool.push_back('1);
      key_pool.push_back(64'd4096);

      // directed: empty ways, extremes, replacement, unused opcode, clear
      add_req(chtd_pkg::OP_PROBE,  64'd0, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_PROBE,  '1, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_INSERT, '1, 16'hFFFF, 2'd3, 8'hFF, 16'h7FFF);
      add_req(chtd_pkg::OP_PROBE,  '1, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_INSERT, 64'd0, 16'h0000, 2'd0, 8'd0, 16'h8000);
      add_req(chtd_pkg::OP_PROBE,  64'd0, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_NONE,   '1, 16'hFFFF, 2'd3, 8'hFF, 16'hFFFF);
      add_ctrl(K_CFG, 13'd1);
      for (int d = 0; d < 5; d++)
         add_req(chtd_pkg::OP_INSERT, 64'(d + 10), 16'(d), 2'(d), 8'(7 - d), 16'(-d));
      for (int d = 0; d < 6; d++)
         add_req(chtd_pkg::OP_PROBE, 64'(d + 10), '0, '0, '0, '0);
      add_req(chtd_pkg::OP_INSERT, 64'd11, 16'hA5A5, 2'd2, 8'd1, 16'h8001);
      add_req(chtd_pkg::OP_PROBE,  64'd11, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_CLEAR,  '0, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_PROBE,  64'd12, '0, '0, '0, '0);
      add_req(chtd_pkg::OP_PROBE,  64'd0, '0, '0, '0, '0);

      // random phases over several cluster counts
      settings = '{13'd4096, 13'd0, 13'd3, 13'd8191, 13'd4097, 13'd7, 13'd1, 13'd4095};
      foreach (settings[s]) begin
         add_ctrl(K_CFG, settings[s]);
         no_gaps = (s == 2);
         add_random(72, s == 1 || s == 5);
         add_ctrl(K_DRAIN, '0);
         add_random(4, 0);
      end
      add_ctrl(K_CFG, 13'($urandom_range(8191)));
      add_random(20, 0);

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // wait for everything to go through, then for the pipeline to empty
      while (pending.size() != 0 || start || replies_due.size() != 0 || quiet < QUIET_CYCLES)
         @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // driver: new values on the falling edge
   always @(negedge clock) begin
      logic nstart, nwe;
      pending_type p;
      nstart = start;
      nwe = 1'b0;
      if (start && took) nstart = 1'b0;
      if (busy || replies_due.size() != 0 || nstart) quiet = 0;
      else quiet++;
      if (!reset && !nstart) begin
         if (idle_cnt > 0) begin
            idle_cnt--;
         end else if (pending.size() != 0) begin
            p = pending[0];
            if (p.kind == K_REQ) begin
               if (p.gap > 0) begin
                  idle_cnt = p.gap - 1;
                  pending[0].gap = 0;
               end else begin
                  req_opcode       <= p.op;
                  req_lookup_key   <= p.key;
                  req_best_move    <= p.move;
                  req_bound_flag   <= p.flag;
                  req_search_depth <= p.depth;
                  req_eval_score   <= p.score;
                  nstart = 1'b1;
                  void'(pending.pop_front());
               end
            end else if (quiet >= QUIET_CYCLES) begin
               // block idle: register write or end of a drain pause
               if (p.kind == K_CFG) begin
                  csr_wdata <= p.cfg;
                  nwe = 1'b1;
               end
               quiet = 0;
               void'(pending.pop_front());
            end
         end
      end
      start  <= nstart;
      csr_we <= nwe;
   end

   // monitor: sample on the rising edge
   always @(posedge clock) begin
      reply_type want;
      took = start && !busy && !reset;
      if (took)
         table_step(req_opcode, req_lookup_key,
                    64'(req_best_move) | (64'(req_bound_flag) << chtd_pkg::FLAG_POS)
                    | (64'(req_search_depth) << chtd_pkg::DEPTH_POS)
                    | (64'(req_eval_score) << chtd_pkg::SCORE_POS));
      if (csr_we) shadow_clusters = csr_wdata;
      if (rsp_valid) begin
         if (replies_due.size() == 0) begin
            report_mismatch("unexpected reply", '0, '0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_key_matched !== want.matched)
               report_mismatch("key_matched", rsp_key_matched, want.matched);
            if (rsp_entry_move !== want.move)
               report_mismatch("entry_move", rsp_entry_move, want.move);
            if (rsp_entry_flag !== want.flag)
               report_mismatch("entry_flag", rsp_entry_flag, want.flag);
            if (rsp_entry_depth !== want.depth)
               report_mismatch("entry_depth", rsp_entry_depth, want.depth);
            if (rsp_entry_score !== want.score)
               report_mismatch("entry_score", rsp_entry_score, want.score);
         end
      end
      // watchdog on cycles with nothing taken
      if (took || rsp_valid || csr_we) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
